>>> rtl/core/dls_pkg.sv
// dls_pkg: shared types and constants for the demod lock supervisor
// holds payload structs, phase codes, command codes and register indexes
// no dependencies
package dls_pkg;

  // command codes of a poll item
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACQ   = 2'd1;
  localparam logic [1:0] CMD_MON   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SCAN_THR   = 3'd0;
  localparam logic [2:0] REG_NORMAL_THR = 3'd1;
  localparam logic [2:0] REG_RUN_LIMIT  = 3'd2;
  localparam logic [2:0] REG_LOCK_CONF  = 3'd3;
  localparam logic [2:0] REG_UNLK_CONF  = 3'd4;
  localparam logic [2:0] REG_TS_ALLOWED = 3'd5;

  // register reset values
  localparam logic [15:0] SCAN_THR_RST   = 16'd255;
  localparam logic [15:0] NORMAL_THR_RST = 16'd300;
  localparam logic [15:0] RUN_LIMIT_RST  = 16'd9;
  localparam logic [1:0]  LOCK_CONF_RST  = 2'd2;
  localparam logic [2:0]  UNLK_CONF_RST  = 3'd4;

  // saturation points of the counters
  localparam logic [15:0] ERR_RUN_MAX = 16'hFFFF;
  localparam logic [1:0]  GOOD_MAX    = 2'd3;
  localparam logic [2:0]  BAD_MAX     = 3'd7;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SCAN   = 3'd1,
    PH_FAIL   = 3'd2,
    PH_SYNC   = 3'd3,
    PH_STABLE = 3'd4,
    PH_LOCKED = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        tune_normal;
    logic        scan_finished;
    logic        scan_found;
    logic        carrier_lock;
    logic        fec_lock;
    logic        psync_lock;
    logic [15:0] packet_errors;
  } poll_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        locked;
    logic        signal_valid;
    logic        lock_notified;
    logic        unlock_notified;
    logic        start_scan;
    logic        soft_reset;
    logic        ts_out_enable;
    logic        pause_locked;
    logic [15:0] error_run;
  } status_t;

  typedef struct packed {
    logic [15:0] scan_err_threshold;
    logic [15:0] normal_err_threshold;
    logic [15:0] err_run_limit;
    logic [1:0]  lock_confirm;
    logic [2:0]  unlock_confirm;
    logic        ts_out_allowed;
  } dls_cfg_t;

  typedef struct packed {
    phase_t      phase_reg;
    logic        lock_flag;
    logic        valid_flag;
    logic        lock_note;
    logic        unlock_note;
    logic [1:0]  good_count;
    logic [2:0]  bad_count;
    logic [15:0] err_run_count;
    logic        scan_mode_sel;
    logic        pause_sel;
  } dls_state_t;

endpackage

>>> rtl/core/dls_update.sv
// dls_update: per-item update of the supervisor state and the result item
// purely combinational; uses dls_pkg for the state, config and payload types
module dls_update (
  input  dls_pkg::dls_state_t state,
  input  dls_pkg::dls_cfg_t   cfg,
  input  dls_pkg::poll_t      poll,
  output dls_pkg::dls_state_t state_next,
  output dls_pkg::status_t    status
);
  import dls_pkg::*;

  dls_state_t s;
  logic       scan_req;
  logic       sreset;
  logic       ts_en;
  logic [15:0] thr;

  // state update for one item
  always_comb begin
    s        = state;
    scan_req = 1'b0;
    sreset   = 1'b0;
    ts_en    = 1'b0;
    thr      = state.scan_mode_sel ? cfg.scan_err_threshold : cfg.normal_err_threshold;
    unique case (poll.command)
      CMD_START, CMD_ACQ: begin
        if (poll.command == CMD_START || state.phase_reg == PH_START) begin
          // start tune
          if (poll.tune_normal) begin
            s.phase_reg     = PH_SYNC;
            s.scan_mode_sel = 1'b0;
          end else begin
            s.phase_reg     = PH_SCAN;
            s.scan_mode_sel = 1'b1;
            scan_req        = 1'b1;
          end
          s.err_run_count = '0;
        end else begin
          unique case (state.phase_reg)
            PH_SCAN: begin
              if (poll.scan_finished && poll.scan_found) begin
                s.phase_reg = PH_SYNC;
              end else if (poll.scan_finished) begin
                s.phase_reg   = PH_FAIL;
                s.lock_flag   = 1'b0;
                s.unlock_note = 1'b1;
                s.lock_note   = 1'b0;
              end
            end
            PH_SYNC: begin
              if (poll.carrier_lock) s.phase_reg = PH_STABLE;
            end
            PH_STABLE: begin
              if (poll.fec_lock) begin
                s.lock_flag   = 1'b1;
                s.valid_flag  = 1'b1;
                s.phase_reg   = PH_LOCKED;
                s.lock_note   = 1'b1;
                s.unlock_note = 1'b0;
              end else begin
                s.phase_reg = PH_SYNC;
              end
            end
            PH_FAIL, PH_LOCKED: begin
            end
            default: s.phase_reg = PH_START;
          endcase
        end
      end
      CMD_MON: begin
        if (poll.psync_lock) begin
          s.bad_count = '0;
          s.pause_sel = 1'b1;
          if (poll.packet_errors >= thr) begin
            // high-error poll extends the run
            if (s.err_run_count != ERR_RUN_MAX) s.err_run_count = s.err_run_count + 16'd1;
            if (s.err_run_count >= cfg.err_run_limit) begin
              sreset          = 1'b1;
              s.lock_flag     = 1'b0;
              s.lock_note     = 1'b0;
              s.unlock_note   = 1'b1;
              s.valid_flag    = 1'b0;
              s.err_run_count = '0;
            end
          end else begin
            // good poll counts toward lock
            s.err_run_count = '0;
            ts_en           = cfg.ts_out_allowed;
            if (!s.lock_flag && !s.lock_note && s.good_count != GOOD_MAX)
              s.good_count = s.good_count + 2'd1;
            if (s.good_count >= cfg.lock_confirm) begin
              s.lock_flag   = 1'b1;
              s.lock_note   = 1'b1;
              s.unlock_note = 1'b0;
              s.valid_flag  = 1'b1;
              s.good_count  = '0;
            end
          end
        end else begin
          // unlocked poll counts toward loss of lock
          s.good_count = '0;
          s.pause_sel  = 1'b0;
          if (s.lock_flag && !s.unlock_note) begin
            if (s.bad_count != BAD_MAX) s.bad_count = s.bad_count + 3'd1;
            if (s.bad_count >= cfg.unlock_confirm) begin
              s.lock_flag     = 1'b0;
              s.lock_note     = 1'b0;
              s.unlock_note   = 1'b1;
              s.valid_flag    = 1'b0;
              s.err_run_count = '0;
              s.bad_count     = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result item shows the state after the update
  always_comb begin
    state_next             = s;
    status.phase           = s.phase_reg;
    status.locked          = s.lock_flag;
    status.signal_valid    = s.valid_flag;
    status.lock_notified   = s.lock_note;
    status.unlock_notified = s.unlock_note;
    status.start_scan      = scan_req;
    status.soft_reset      = sreset;
    status.ts_out_enable   = ts_en;
    status.pause_locked    = s.pause_sel;
    status.error_run       = s.err_run_count;
  end

endmodule

>>> rtl/core/demod_lock_supervisor.sv
// demod_lock_supervisor: top level of the receiver lock supervisor
// holds the config registers, poll register, state and result register
// depends on dls_pkg and dls_update
//
// usage:
//   poll channel (poll_valid, poll_stall, poll) carries one command item:
//   start tune, acquisition poll or monitoring poll with lock indications.
//   status channel (status_valid, status_stall, status) returns exactly one
//   item per poll with the phase, lock flags, pulses and error run length.
//   config port (cfg_write, cfg_index, cfg_data) writes one register per
//   cycle; write only while no poll is in flight.
// flow: a poll passes through the poll register, then the result register;
//   throughput one item per cycle while the status channel is not stalled,
//   with the combinational state update between the two registers.
// reset: rst (synchronous, active high) loads register defaults, returns
//   the phase to start, clears all flags and counters and empties both
//   registers.
// stall: a stalled status item holds; the poll register keeps one item
//   waiting; poll_stall rises only when both are full and status stalls.
module demod_lock_supervisor (
  input  logic             clk,
  input  logic             rst,
  input  logic             poll_valid,
  output logic             poll_stall,
  input  dls_pkg::poll_t   poll,
  output logic             status_valid,
  input  logic             status_stall,
  output dls_pkg::status_t status,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import dls_pkg::*;

  dls_cfg_t   cfg;
  dls_state_t state;
  dls_state_t state_next;
  status_t    result_next;
  poll_t      poll_q;
  logic       poll_q_valid;
  logic       advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_err_threshold   <= SCAN_THR_RST;
      cfg.normal_err_threshold <= NORMAL_THR_RST;
      cfg.err_run_limit        <= RUN_LIMIT_RST;
      cfg.lock_confirm         <= LOCK_CONF_RST;
      cfg.unlock_confirm       <= UNLK_CONF_RST;
      cfg.ts_out_allowed       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCAN_THR:   cfg.scan_err_threshold   <= cfg_data;
        REG_NORMAL_THR: cfg.normal_err_threshold <= cfg_data;
        REG_RUN_LIMIT:  cfg.err_run_limit        <= cfg_data;
        REG_LOCK_CONF:  cfg.lock_confirm         <= cfg_data[1:0];
        REG_UNLK_CONF:  cfg.unlock_confirm       <= cfg_data[2:0];
        REG_TS_ALLOWED: cfg.ts_out_allowed       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the update runs when the result register is free or draining
  assign advance    = poll_q_valid && (!status_valid || !status_stall);
  assign poll_stall = poll_q_valid && !advance;

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (!poll_stall) begin
      poll_q_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && !poll_stall) begin
      poll_q <= poll;
    end
  end

  // state update
  dls_update u_update (
    .state      (state),
    .cfg        (cfg),
    .poll       (poll_q),
    .state_next (state_next),
    .status     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase_reg     <= PH_START;
      state.lock_flag     <= 1'b0;
      state.valid_flag    <= 1'b0;
      state.lock_note     <= 1'b0;
      state.unlock_note   <= 1'b0;
      state.good_count    <= '0;
      state.bad_count     <= '0;
      state.err_run_count <= '0;
      state.scan_mode_sel <= 1'b0;
      state.pause_sel     <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= result_next;
    end
  end

endmodule

>>> rtl/core/dls_checker.sv
// dls_checker: port-level assertions for the demod lock supervisor
// depends on dls_pkg; bound to demod_lock_supervisor at the end of this file
module dls_checker (
  input logic             clk,
  input logic             rst,
  input logic             poll_valid,
  input logic             poll_stall,
  input dls_pkg::poll_t   poll,
  input logic             status_valid,
  input logic             status_stall,
  input dls_pkg::status_t status,
  input logic             cfg_write,
  input logic [2:0]       cfg_index,
  input logic [15:0]      cfg_data
);
  import dls_pkg::*;

  // a stalled status item holds
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_stall |=> status_valid && $stable(status))
    else $error("status item changed under stall");

  // soft reset always comes with a forced unlock
  a_sreset_unlock: assert property (@(posedge clk) disable iff (rst)
    status_valid && status.soft_reset |->
      !status.locked && !status.signal_valid && status.unlock_notified
      && status.error_run == 16'd0)
    else $error("soft reset without unlock");

  // scan request only on entry to the scan phase
  a_scan_phase: assert property (@(posedge clk) disable iff (rst)
    status_valid && status.start_scan |->
      status.phase == PH_SCAN && status.error_run == 16'd0)
    else $error("start scan outside scan phase");

  // declared lock implies a valid signal
  a_lock_valid: assert property (@(posedge clk) disable iff (rst)
    status_valid && status.locked |-> status.signal_valid)
    else $error("locked without signal valid");

  // transport stream enable only on a packet-sync poll
  a_ts_pause: assert property (@(posedge clk) disable iff (rst)
    status_valid && status.ts_out_enable |-> status.pause_locked)
    else $error("ts output enable without locked pause");

endmodule

bind demod_lock_supervisor dls_checker u_dls_checker (.*);
